@@ src/ecd_pkg.sv @@
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, opcodes and constant tables for the epoch to calendar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecd_pkg;

   // Field widths
   localparam int EPOCH_W  = 32;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int DAYS_W   = 16;  // whole days since epoch, at most 49710
   localparam int PC_W     = 4;

   // Reciprocals: q = (t * K) >> S is exact for every 32-bit t
   localparam logic [31:0] RECIP_60 = 32'h8888_8889;  // shift 37
   localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;  // shift 36

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR     = 12'd1970;
   localparam logic [6:0]         EPOCH_MOD_100  = 7'd70;
   localparam logic [8:0]         EPOCH_MOD_400  = 9'd370;
   localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;

   // Datapath opcodes
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_MUL60 = 3'd1;
   localparam logic [2:0] OP_SEC   = 3'd2;
   localparam logic [2:0] OP_MIN   = 3'd3;
   localparam logic [2:0] OP_MUL24 = 3'd4;
   localparam logic [2:0] OP_HOUR  = 3'd5;
   localparam logic [2:0] OP_YEAR  = 3'd6;
   localparam logic [2:0] OP_MONTH = 3'd7;

   // Jump conditions
   localparam logic [2:0] COND_NEXT   = 3'd0;  // fall through
   localparam logic [2:0] COND_ALWAYS = 3'd1;
   localparam logic [2:0] COND_IDLE   = 3'd2;  // no start seen
   localparam logic [2:0] COND_YEAR   = 3'd3;  // another whole year remains
   localparam logic [2:0] COND_MONTH  = 3'd4;  // another whole month remains

   // Program addresses
   localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
   localparam logic [PC_W-1:0] PC_YEAR  = 4'd7;
   localparam logic [PC_W-1:0] PC_MONTH = 4'd8;
   localparam logic [PC_W-1:0] PC_DONE  = 4'd9;

   typedef struct packed {
      logic [2:0]      op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
      logic            strobe;
   } uword_type;

   typedef struct packed {
      logic [2:0] op;
      logic       load;
   } ctl_type;

   typedef struct packed {
      logic year_more;
      logic month_more;
   } status_type;

   // Control store
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_LOAD, cond: COND_ALWAYS, target: PC_WAIT, strobe: 1'b0};
      unique case (pc)
         4'd0: w = '{op: OP_LOAD,  cond: COND_IDLE,  target: PC_WAIT,  strobe: 1'b0};
         4'd1: w = '{op: OP_MUL60, cond: COND_NEXT,  target: PC_WAIT,  strobe: 1'b0};
         4'd2: w = '{op: OP_SEC,   cond: COND_NEXT,  target: PC_WAIT,  strobe: 1'b0};
         4'd3: w = '{op: OP_MUL60, cond: COND_NEXT,  target: PC_WAIT,  strobe: 1'b0};
         4'd4: w = '{op: OP_MIN,   cond: COND_NEXT,  target: PC_WAIT,  strobe: 1'b0};
         4'd5: w = '{op: OP_MUL24, cond: COND_NEXT,  target: PC_WAIT,  strobe: 1'b0};
         4'd6: w = '{op: OP_HOUR,  cond: COND_NEXT,  target: PC_WAIT,  strobe: 1'b0};
         4'd7: w = '{op: OP_YEAR,  cond: COND_YEAR,  target: PC_YEAR,  strobe: 1'b0};
         4'd8: w = '{op: OP_MONTH, cond: COND_MONTH, target: PC_MONTH, strobe: 1'b0};
         4'd9: w = '{op: OP_LOAD,  cond: COND_ALWAYS, target: PC_WAIT, strobe: 1'b1};
         default: w = '{op: OP_LOAD, cond: COND_ALWAYS, target: PC_WAIT, strobe: 1'b0};
      endcase
      return w;
   endfunction

   // Days in month, February by leap flag
   function automatic logic [4:0] month_length_of(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [4:0] d;
      d = 5'd31;
      case (m) inside
         MONTH_FEB:               d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:                 d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ src/ecd_seq.sv @@
// ----------------------------------------------------------------------------
// ecd_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ecd_pkg::status_type status,
   output ecd_pkg::ctl_type         ctl,
   output logic                     busy,
   output logic                     strobe
);

   logic [ecd_pkg::PC_W-1:0] pc_ff, pc_in;
   ecd_pkg::uword_type       uw;
   logic                     take;

   assign uw = ecd_pkg::ucode(pc_ff);

   always_comb begin
      unique case (uw.cond)
         ecd_pkg::COND_ALWAYS: take = 1'b1;
         ecd_pkg::COND_IDLE:   take = !start;
         ecd_pkg::COND_YEAR:   take = status.year_more;
         ecd_pkg::COND_MONTH:  take = status.month_more;
         default:              take = 1'b0;
      endcase
      pc_in = take ? uw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ecd_pkg::PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy     = (pc_ff != ecd_pkg::PC_WAIT);
   assign strobe   = uw.strobe;
   assign ctl.op   = uw.op;
   assign ctl.load = (pc_ff == ecd_pkg::PC_WAIT) && start;

endmodule

`default_nettype wire

@@ src/ecd_dp.sv @@
// ----------------------------------------------------------------------------
// ecd_dp
// Datapath: reciprocal multiply, remainders, year and month subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module ecd_dp (
   input  wire logic                            clock,
   input  wire ecd_pkg::ctl_type                ctl,
   input  wire logic [ecd_pkg::EPOCH_W-1:0]     epoch_seconds,
   output ecd_pkg::status_type                  status,
   output logic [ecd_pkg::YEAR_W-1:0]           cal_year,
   output logic [ecd_pkg::MONTH_W-1:0]          cal_month,
   output logic [ecd_pkg::DAY_W-1:0]            cal_day,
   output logic [ecd_pkg::HOUR_W-1:0]           cal_hour,
   output logic [ecd_pkg::MINUTE_W-1:0]         cal_minute,
   output logic [ecd_pkg::SECOND_W-1:0]         cal_second
);

   logic [31:0]                    t_ff, t_in;
   logic [63:0]                    prod_ff, prod_in;
   logic [31:0]                    mul_k;
   logic [26:0]                    q60;
   logic [15:0]                    q24;
   logic [31:0]                    rem60, rem24;
   logic [ecd_pkg::DAYS_W-1:0]     days_ff, days_in;
   logic [ecd_pkg::YEAR_W-1:0]     year_ff, year_in;
   logic [6:0]                     m100_ff, m100_in;
   logic [8:0]                     m400_ff, m400_in;
   logic [ecd_pkg::MONTH_W-1:0]    month_ff, month_in;
   logic [ecd_pkg::SECOND_W-1:0]   sec_ff, sec_in;
   logic [ecd_pkg::MINUTE_W-1:0]   min_ff, min_in;
   logic [ecd_pkg::HOUR_W-1:0]     hour_ff, hour_in;
   logic                           leap;
   logic [8:0]                     diy;
   logic [4:0]                     dim;

   assign mul_k   = (ctl.op == ecd_pkg::OP_MUL24) ? ecd_pkg::RECIP_24 : ecd_pkg::RECIP_60;
   assign prod_in = {32'd0, t_ff} * {32'd0, mul_k};
   assign q60     = prod_ff[63:37];
   assign q24     = prod_ff[51:36];
   // t - q*60 and t - q*24 by shift and add
   assign rem60   = t_ff - (({5'd0, q60} << 6) - ({5'd0, q60} << 2));
   assign rem24   = t_ff - (({16'd0, q24} << 4) + ({16'd0, q24} << 3));

   assign leap = ((year_ff[1:0] == 2'd0) && (m100_ff != 7'd0)) || (m400_ff == 9'd0);
   assign diy  = leap ? 9'd366 : 9'd365;
   assign dim  = ecd_pkg::month_length_of(month_ff, leap);

   assign status.year_more  = (days_ff >= {7'd0, diy});
   assign status.month_more = (month_ff != ecd_pkg::MONTH_DEC) && (days_ff >= {11'd0, dim});

   always_comb begin
      t_in     = t_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      m100_in  = m100_ff;
      m400_in  = m400_ff;
      month_in = month_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      unique case (ctl.op)
         ecd_pkg::OP_LOAD: begin
            if (ctl.load) begin
               t_in     = epoch_seconds;
               year_in  = ecd_pkg::EPOCH_YEAR;
               m100_in  = ecd_pkg::EPOCH_MOD_100;
               m400_in  = ecd_pkg::EPOCH_MOD_400;
               month_in = ecd_pkg::MONTH_JAN;
            end
         end
         ecd_pkg::OP_SEC: begin
            sec_in = rem60[5:0];
            t_in   = {5'd0, q60};
         end
         ecd_pkg::OP_MIN: begin
            min_in = rem60[5:0];
            t_in   = {5'd0, q60};
         end
         ecd_pkg::OP_HOUR: begin
            hour_in = rem24[4:0];
            days_in = q24;
         end
         ecd_pkg::OP_YEAR: begin
            if (status.year_more) begin
               days_in = days_ff - {7'd0, diy};
               year_in = year_ff + 1'b1;
               m100_in = (m100_ff == 7'd99)  ? 7'd0 : m100_ff + 1'b1;
               m400_in = (m400_ff == 9'd399) ? 9'd0 : m400_ff + 1'b1;
            end
         end
         ecd_pkg::OP_MONTH: begin
            if (status.month_more) begin
               days_in  = days_ff - {11'd0, dim};
               month_in = month_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      prod_ff  <= prod_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      m100_ff  <= m100_in;
      m400_ff  <= m400_in;
      month_ff <= month_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
   end

   assign cal_year   = year_ff;
   assign cal_month  = month_ff;
   assign cal_day    = days_ff[4:0] + 1'b1;
   assign cal_hour   = hour_ff;
   assign cal_minute = min_ff;
   assign cal_second = sec_ff;

endmodule

`default_nettype wire

@@ src/epoch_seconds_to_calendar_date_unit.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_unit
// Converts a 32-bit count of seconds since 1970-01-01 into Gregorian
// year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  request   start / busy         req_epoch_seconds
//  response  rsp_valid (strobe)   rsp_cal_year .. rsp_cal_second
//
//  A beat runs from the accepting edge to the edge that ends the strobe. Its
//  length is set by the year and month subtraction loops of the microcode,
//  which step through the whole years past 1970 and the whole months in the
//  last year; the divisions by 60, 60 and 24 take two steps each on one
//  shared reciprocal multiplier.
//  Reset clears the step counter only; the block is ready the cycle after.
//  The response strobe is high for one cycle and cannot be stalled; the
//  next request is taken the cycle after the strobe.
//
`default_nettype none

module epoch_seconds_to_calendar_date_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [ecd_pkg::EPOCH_W-1:0]     req_epoch_seconds,
   output logic                                 rsp_valid,
   output logic [ecd_pkg::YEAR_W-1:0]           rsp_cal_year,
   output logic [ecd_pkg::MONTH_W-1:0]          rsp_cal_month,
   output logic [ecd_pkg::DAY_W-1:0]            rsp_cal_day,
   output logic [ecd_pkg::HOUR_W-1:0]           rsp_cal_hour,
   output logic [ecd_pkg::MINUTE_W-1:0]         rsp_cal_minute,
   output logic [ecd_pkg::SECOND_W-1:0]         rsp_cal_second
);

   ecd_pkg::ctl_type    ctl;
   ecd_pkg::status_type status;

   // Sequencer: step counter and control store, accepts a beat at step zero
   ecd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl),
      .busy   (busy),
      .strobe (rsp_valid)
   );

   // Datapath: holds every field; outputs stay stable through the strobe
   ecd_dp u_dp (
      .clock         (clock),
      .ctl           (ctl),
      .epoch_seconds (req_epoch_seconds),
      .status        (status),
      .cal_year      (rsp_cal_year),
      .cal_month     (rsp_cal_month),
      .cal_day       (rsp_cal_day),
      .cal_hour      (rsp_cal_hour),
      .cal_minute    (rsp_cal_minute),
      .cal_second    (rsp_cal_second)
   );

endmodule

`default_nettype wire
